>>> rtl/cubp_pkg.sv
// Shared types, constants and helper functions for the code unit bit packer.
package cubp_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned UnitMax    = 64;
  localparam int unsigned LenW       = 7;
  localparam int unsigned AccW       = UnitMax + ByteBits;
  localparam int unsigned CountW     = 3;
  localparam int unsigned NbytesW    = 4;
  localparam logic [LenW-1:0] UnitLenReset = 7'd8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Clamps a programmed unit length into the range 1 to 64.
  function automatic logic [LenW-1:0] eff_width(input logic [LenW-1:0] len);
    logic [LenW-1:0] w;
    begin
      if (len == '0) begin
        w = 7'd1;
      end else if (len > 7'(UnitMax)) begin
        w = 7'(UnitMax);
      end else begin
        w = len;
      end
      return w;
    end
  endfunction

  // Returns a mask with the low w bits set, for w in 1 to 64.
  function automatic logic [UnitMax-1:0] width_mask(input logic [LenW-1:0] w);
    logic [UnitMax-1:0] m;
    begin
      if (w >= 7'(UnitMax)) begin
        m = '1;
      end else begin
        m = (64'd1 << w[5:0]) - 64'd1;
      end
      return m;
    end
  endfunction

endpackage

>>> rtl/code_unit_bit_packer.sv
// Top level of the code unit bit packer: LSB-first packing of variable-width units into bytes.

// Packs code units of the programmed width (1 to 64 bits) into a byte stream, least
// significant bit first, holding up to 7 leftover bits between units. An input beat with
// in_tuser low writes a unit; with in_tuser high it flushes the held bits as one byte if
// any are held. Each accepted input beat merges the unit into a 72-bit shift register, which
// then sends out its bytes (0 to 8) at one byte per cycle while the output register is free;
// the byte-wide shift of that register sets the pace. A single output register holds one
// byte; while it waits on out_tready the byte sequence pauses. Once the final byte of an
// item is loaded the next input beat can be taken while that byte still waits. The tlast
// flag marks the final byte produced by each input beat.
module code_unit_bit_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,     // unit_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // unit_value
  input  logic        in_tuser,     // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // out_byte
  output logic        out_tlast     // last
);

  cubp_pkg::state_t state_r, state_nxt;

  logic [cubp_pkg::LenW-1:0]     weff_r, weff_nxt;
  logic [cubp_pkg::UnitMax-1:0]  mask_r, mask_nxt;
  logic [6:0]                    partial_r, partial_nxt;
  logic [cubp_pkg::CountW-1:0]   count_r, count_nxt;
  logic [cubp_pkg::AccW-1:0]     acc_r, acc_nxt;
  logic [cubp_pkg::CountW-1:0]   rem_r, rem_nxt;
  logic [cubp_pkg::NbytesW-1:0]  left_r, left_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [7:0]                    out_tdata_r, out_tdata_nxt;
  logic                          out_tlast_r, out_tlast_nxt;

  logic                          in_acc;
  logic                          out_free;
  logic [cubp_pkg::AccW-1:0]     acc_load;
  logic [cubp_pkg::LenW-1:0]     total;
  logic [cubp_pkg::NbytesW-1:0]  n_load;
  logic [cubp_pkg::CountW-1:0]   rem_load;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == cubp_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  always_comb begin
    total = {4'b0, count_r} + weff_r;
    if (in_tuser == cubp_pkg::ACT_FLUSH) begin
      acc_load = {65'b0, partial_r};
      n_load   = (count_r != '0) ? 4'd1 : 4'd0;
      rem_load = '0;
    end else begin
      acc_load = ({8'b0, in_tdata & mask_r} << count_r) | {65'b0, partial_r};
      n_load   = total[6:3];
      rem_load = total[2:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    weff_nxt       = weff_r;
    mask_nxt       = mask_r;
    partial_nxt    = partial_r;
    count_nxt      = count_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    left_nxt       = left_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    if (cfg_valid && cfg_ready) begin
      weff_nxt = cubp_pkg::eff_width(cfg_data);
      mask_nxt = cubp_pkg::width_mask(cubp_pkg::eff_width(cfg_data));
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      cubp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (n_load == '0) begin
            partial_nxt = acc_load[6:0];
            count_nxt   = rem_load;
          end else begin
            acc_nxt   = acc_load;
            rem_nxt   = rem_load;
            left_nxt  = n_load;
            state_nxt = cubp_pkg::ST_EMIT;
          end
        end
      end
      cubp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = acc_r[7:0];
          out_tlast_nxt  = (left_r == 4'd1);
          acc_nxt        = acc_r >> cubp_pkg::ByteBits;
          left_nxt       = left_r - 4'd1;
          if (left_r == 4'd1) begin
            partial_nxt = acc_r[14:8];
            count_nxt   = rem_r;
            state_nxt   = cubp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cubp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cubp_pkg::ST_IDLE;
      weff_r       <= cubp_pkg::UnitLenReset;
      mask_r       <= cubp_pkg::width_mask(cubp_pkg::UnitLenReset);
      partial_r    <= '0;
      count_r      <= '0;
      left_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      weff_r       <= weff_nxt;
      mask_r       <= mask_nxt;
      partial_r    <= partial_nxt;
      count_r      <= count_nxt;
      left_r       <= left_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

`ifndef SYNTHESIS
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r >> count_r) == 7'd0)
    else $error("Held bits above the bit count are not zero.");

  a_emit_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cubp_pkg::ST_EMIT) |-> (left_r != '0 && left_r <= 4'd8))
    else $error("Byte counter out of range while emitting.");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (weff_r != '0) && (weff_r <= 7'(cubp_pkg::UnitMax)) && mask_r[0])
    else $error("Effective unit width or mask is inconsistent.");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cubp_pkg::ST_EMIT && out_free && left_r == 4'd1)
      |=> (state_r == cubp_pkg::ST_IDLE && out_tvalid_r && out_tlast_r))
    else $error("Final byte of a beat did not end the emit sequence.");
`endif

endmodule
